// ===== sv/gloh_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the great-circle offset core.
// No dependencies; the CORDIC, square root and core files refer to this package by scoped names.
package gloh_pkg;

  // Q62 fixed point: 1.0 is 2^62
  localparam logic signed [63:0] ONE_Q62 = 64'sh4000_0000_0000_0000;
  // CORDIC gain compensation 0.607252935... in Q62
  localparam logic signed [63:0] GAIN_Q62 = 64'sd2800459870029452945;

  // Angle units are 0.5e-7 degree
  localparam logic signed [33:0] UNITS_TURN = 34'sd7200000000;
  localparam logic signed [33:0] UNITS_Q1 = 34'sd900000000;
  localparam logic signed [33:0] UNITS_Q2 = 34'sd2700000000;
  localparam logic signed [33:0] UNITS_Q3 = 34'sd4500000000;
  localparam logic signed [33:0] UNITS_Q4 = 34'sd6300000000;
  localparam logic signed [33:0] UNITS_QUARTER = 34'sd1800000000;

  // Radians per angle unit in Q62, rounded
  localparam logic [63:0] RAD64 = (64'hC90F_DAA2_2168_C235 + 64'd1800000000) / 64'd3600000000;
  localparam logic signed [32:0] RAD_PER_UNIT = {1'b0, RAD64[31:0]};

  // Sphere radius in hundredths of a millimeter
  localparam logic signed [63:0] RADIUS_CENTI_MM = 64'sd637279756085;
  // Reciprocal of 100 scaled by 2^49, rounded up; exact for inputs below 2^42
  localparam int RECIP_SHIFT = 49;
  localparam logic [63:0] RECIP64 = ((64'd1 << RECIP_SHIFT) / 64'd100) + 64'd1;
  localparam logic signed [63:0] RECIP_100 = RECIP64;
  localparam logic signed [63:0] ROUND_HALF = 64'sd50;

  // Configuration register map (selected by paddr[2])
  localparam logic REG_FACING_NORTH = 1'b0;
  localparam logic REG_REACH_THRESHOLD = 1'b1;
  localparam logic [19:0] REACH_THRESHOLD_RST = 20'd2000;

  // Square root pipeline depth: one result bit per stage
  localparam int SQRT_STAGES = 63;

  // CORDIC micro-rotation angle atan(2^-i) in Q62
  function automatic logic signed [63:0] atan_q62(input int i);
    logic signed [63:0] sum;
    logic signed [63:0] term;
    int e;
    sum = '0;
    if (i == 0) begin
      sum = 64'sh3243_F6A8_885A_308D;
    end else begin
      for (int k = 0; k < 32; k++) begin
        e = i * (2 * k + 1);
        if (e <= 62) begin
          term = $signed((64'd1 << (62 - e)) / 64'(2 * k + 1));
          sum = (k % 2 == 1) ? sum - term : sum + term;
        end
      end
    end
    return sum;
  endfunction

  // Clamp a Q62 value to [0, 1]
  function automatic logic signed [63:0] clamp_unit(input logic signed [63:0] v);
    logic signed [63:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > ONE_Q62) begin
      r = ONE_Q62;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== sv/gloh_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for fix/goal transactions and result transactions.
// No dependencies.
interface gloh_in_if;
  logic valid;
  logic ready;
  logic signed [30:0] robot_latitude;
  logic signed [31:0] robot_longitude;
  logic signed [30:0] goal_latitude;
  logic signed [31:0] goal_longitude;

  modport source (output valid, robot_latitude, robot_longitude, goal_latitude,
                  goal_longitude, input ready);
  modport sink (input valid, robot_latitude, robot_longitude, goal_latitude,
                goal_longitude, output ready);
endinterface

interface gloh_out_if;
  logic valid;
  logic ready;
  logic signed [35:0] x_offset_mm;
  logic signed [35:0] y_offset_mm;
  logic [34:0] distance_mm;
  logic goal_reached;

  modport source (output valid, x_offset_mm, y_offset_mm, distance_mm, goal_reached,
                  input ready);
  modport sink (input valid, x_offset_mm, y_offset_mm, distance_mm, goal_reached,
                output ready);
endinterface

// ===== sv/gloh_dly.sv =====
`timescale 1ns / 1ps
// Stall-aware delay line that keeps sideband data aligned with the pipeline.
// No package dependencies.
module gloh_dly #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] tap_w [0:N];

  assign tap_w[0] = d_i;

  // Advance one tap per enabled cycle
  for (genvar s = 0; s < N; s++) begin : g_tap
    logic [W-1:0] tap_r;
    always_ff @(posedge clk) begin
      if (en) begin
        tap_r <= tap_w[s];
      end
    end
    assign tap_w[s+1] = tap_r;
  end

  assign q_o = tap_w[N];

endmodule

// ===== sv/gloh_mul.sv =====
`timescale 1ns / 1ps
// Three-stage signed 64x64 multiplier built from four 32x32 partial products.
// Result is the sign-magnitude product shifted right by SHIFT, truncated to 64 bits.
module gloh_mul #(
  parameter int SHIFT = 62
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] a_i,
  input  logic signed [63:0] b_i,
  output logic signed [63:0] p_o
);

  logic        neg_a_r, neg_b_r;
  logic [63:0] ua_r, ub_r;
  logic [63:0] pll_r, plh_r, phl_r, phh_r;
  logic [127:0] full_w;
  logic [63:0]  mag_w;
  logic signed [63:0] p_r;

  // Take magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      neg_a_r <= a_i[63] ^ b_i[63];
      ua_r    <= a_i[63] ? 64'(-a_i) : 64'(a_i);
      ub_r    <= b_i[63] ? 64'(-b_i) : 64'(b_i);
    end
  end

  // Partial products
  always_ff @(posedge clk) begin
    if (en) begin
      neg_b_r <= neg_a_r;
      pll_r   <= ua_r[31:0] * ub_r[31:0];
      plh_r   <= ua_r[31:0] * ub_r[63:32];
      phl_r   <= ua_r[63:32] * ub_r[31:0];
      phh_r   <= ua_r[63:32] * ub_r[63:32];
    end
  end

  // Sum partials, select the scaled slice, restore the sign
  assign full_w = {64'd0, pll_r} + {32'd0, plh_r, 32'd0} + {32'd0, phl_r, 32'd0}
                + {phh_r, 64'd0};
  assign mag_w = full_w[SHIFT+63:SHIFT];

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= neg_b_r ? -$signed(mag_w) : $signed(mag_w);
    end
  end

  assign p_o = p_r;

endmodule

// ===== sv/gloh_cordic.sv =====
`timescale 1ns / 1ps
// Pipelined CORDIC, one micro-rotation per register stage, rotation or vectoring mode.
// Depends on gloh_pkg for the arctangent table function.
module gloh_cordic #(
  parameter int STEPS = 32,
  parameter bit VECTOR = 1'b0
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] x_i,
  input  logic signed [63:0] y_i,
  input  logic signed [63:0] z_i,
  output logic signed [63:0] x_o,
  output logic signed [63:0] y_o,
  output logic signed [63:0] z_o
);

  logic signed [63:0] x_w [0:STEPS];
  logic signed [63:0] y_w [0:STEPS];
  logic signed [63:0] z_w [0:STEPS];

  assign x_w[0] = x_i;
  assign y_w[0] = y_i;
  assign z_w[0] = z_i;

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic signed [63:0] ATAN = gloh_pkg::atan_q62(i);
    logic               dir;
    logic signed [63:0] dx, dy;
    logic signed [63:0] x_r, y_r, z_r;

    // Rotate toward zero angle, or toward the x axis in vectoring mode
    always_comb begin
      dir = VECTOR ? (y_w[i] < 0) : (z_w[i] >= 0);
      dx  = y_w[i] >>> i;
      dy  = x_w[i] >>> i;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r <= dir ? x_w[i] - dx : x_w[i] + dx;
        y_r <= dir ? y_w[i] + dy : y_w[i] - dy;
        z_r <= dir ? z_w[i] - ATAN : z_w[i] + ATAN;
      end
    end

    assign x_w[i+1] = x_r;
    assign y_w[i+1] = y_r;
    assign z_w[i+1] = z_r;
  end

  assign x_o = x_w[STEPS];
  assign y_o = y_w[STEPS];
  assign z_o = z_w[STEPS];

endmodule

// ===== sv/gloh_sqrt.sv =====
`timescale 1ns / 1ps
// Pipelined digit-by-digit square root: largest t with t*t <= v * 2^62.
// Depends on gloh_pkg for the stage count.
module gloh_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [62:0] v_i,
  output logic [62:0] root_o
);

  localparam int STG = gloh_pkg::SQRT_STAGES;

  logic [64:0] rem_w  [0:STG];
  logic [62:0] root_w [0:STG];
  logic [62:0] v_w    [0:STG];

  assign rem_w[0]  = '0;
  assign root_w[0] = '0;
  assign v_w[0]    = v_i;

  for (genvar s = 0; s < STG; s++) begin : g_stage
    localparam int P = STG - 1 - s;
    logic [125:0] rad;
    logic [66:0]  rem_sh, trial;
    logic         take;
    logic [64:0]  rem_r;
    logic [62:0]  root_r, v_r;

    // Bring down the next radicand bit pair and try a subtract
    always_comb begin
      rad    = {v_w[s], 63'd0};
      rad    = rad >> 1;
      rem_sh = {rem_w[s], rad[2*P+1 -: 2]};
      trial  = {2'b00, root_w[s], 2'b01};
      take   = rem_sh >= trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r  <= take ? 65'(rem_sh - trial) : rem_sh[64:0];
        root_r <= {root_w[s][61:0], take};
        v_r    <= v_w[s];
      end
    end

    assign rem_w[s+1]  = rem_r;
    assign root_w[s+1] = root_r;
    assign v_w[s+1]    = v_r;
  end

  assign root_o = root_w[STG];

endmodule

// ===== sv/gps_local_offset_haversine_core.sv =====
`timescale 1ns / 1ps
// Great-circle offset core: one fix/goal transaction in per cycle when not stalled, one result out.
// Depends on gloh_pkg, gloh_if, gloh_dly, gloh_mul, gloh_cordic and gloh_sqrt.
//
// The core accepts one transaction per clock unless back pressure stalls it, and
// returns each result in order. The pipeline is made of the rotation CORDIC chain
// (CORDIC_STEPS stages), the 63-stage square root, the vectoring CORDIC chain
// (CORDIC_STEPS stages), four three-stage multipliers in series and a few
// alignment registers. Every stage holds while the result register is full and
// not taken, so back pressure stalls the whole pipe without loss. Configuration
// writes take effect on results captured in the result register after the write.
module gps_local_offset_haversine_core #(
  parameter int CORDIC_STEPS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  gloh_in_if.sink          in_ch,
  gloh_out_if.source       out_ch,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int LAT = 80 + 2 * CORDIC_STEPS;

  logic en;

  // ---------------- configuration registers ----------------
  logic        facing_r;
  logic [19:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      facing_r <= 1'b0;
      thr_r    <= gloh_pkg::REACH_THRESHOLD_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        gloh_pkg::REG_FACING_NORTH:    facing_r <= pwdata[0];
        gloh_pkg::REG_REACH_THRESHOLD: thr_r    <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[2])
      gloh_pkg::REG_FACING_NORTH:    prdata = {31'd0, facing_r};
      gloh_pkg::REG_REACH_THRESHOLD: prdata = {12'd0, thr_r};
      default:                       prdata = '0;
    endcase
  end

  // ---------------- valid tracking and flow control ----------------
  logic [LAT-1:0] vld_r;

  assign en          = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_ch.valid};
    end
  end

  // Offset signs travel beside the item to the result stage
  logic [1:0] sgn_in, sgn_d;

  assign sgn_in = {in_ch.robot_latitude < in_ch.goal_latitude,
                   in_ch.robot_longitude < in_ch.goal_longitude};

  gloh_dly #(.W(2), .N(LAT-1)) u_sgn_dly (
    .clk(clk), .en(en), .d_i(sgn_in), .q_o(sgn_d)
  );

  // ---------------- angle reduction ----------------
  // Lanes: latitude difference, longitude difference, 2*robot lat, 2*goal lat
  logic signed [33:0] ang_w [0:3];

  assign ang_w[0] = 34'(in_ch.goal_latitude) - 34'(in_ch.robot_latitude);
  assign ang_w[1] = 34'(in_ch.goal_longitude) - 34'(in_ch.robot_longitude);
  assign ang_w[2] = 34'(in_ch.robot_latitude) <<< 1;
  assign ang_w[3] = 34'(in_ch.goal_latitude) <<< 1;

  logic signed [63:0] trig_r [0:3];

  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic signed [33:0] m, r;
    logic [2:0]         q;
    logic signed [30:0] res_r;
    logic [1:0]         quad_r, quad2_r, quad_d;
    logic signed [63:0] z0_r;
    logic signed [63:0] cx, cy;

    // Fold into one turn, then to the nearest quarter turn
    always_comb begin
      m = (ang_w[l] < 0) ? ang_w[l] + gloh_pkg::UNITS_TURN : ang_w[l];
      q = 3'(m >= gloh_pkg::UNITS_Q1) + 3'(m >= gloh_pkg::UNITS_Q2)
        + 3'(m >= gloh_pkg::UNITS_Q3) + 3'(m >= gloh_pkg::UNITS_Q4);
      r = m - 34'($signed({1'b0, q}) * gloh_pkg::UNITS_QUARTER);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        res_r  <= r[30:0];
        quad_r <= q[1:0];
      end
    end

    // Scale the residual to radians in Q62
    always_ff @(posedge clk) begin
      if (en) begin
        z0_r    <= 64'(res_r) * 64'(gloh_pkg::RAD_PER_UNIT);
        quad2_r <= quad_r;
      end
    end

    gloh_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0)) u_rot (
      .clk(clk), .en(en),
      .x_i(gloh_pkg::GAIN_Q62), .y_i(64'sd0), .z_i(z0_r),
      .x_o(cx), .y_o(cy), .z_o()
    );

    gloh_dly #(.W(2), .N(CORDIC_STEPS)) u_quad_dly (
      .clk(clk), .en(en), .d_i(quad2_r), .q_o(quad_d)
    );

    // Quadrant fix-up: sine for the difference lanes, cosine for the others
    always_ff @(posedge clk) begin
      if (en) begin
        case (quad_d)
          2'd0:    trig_r[l] <= (l < 2) ? cy : cx;
          2'd1:    trig_r[l] <= (l < 2) ? cx : -cy;
          2'd2:    trig_r[l] <= (l < 2) ? -cy : -cx;
          default: trig_r[l] <= (l < 2) ? -cx : cy;
        endcase
      end
    end
  end

  // ---------------- haversine terms ----------------
  logic signed [63:0] hl2_raw, hn2_raw, cr2_raw, crcg;
  logic signed [63:0] ax_raw, term, hl2_d;
  logic signed [63:0] hl2_c;

  gloh_mul #(.SHIFT(62)) u_mul_hl2 (
    .clk(clk), .en(en), .a_i(trig_r[0]), .b_i(trig_r[0]), .p_o(hl2_raw)
  );
  gloh_mul #(.SHIFT(62)) u_mul_hn2 (
    .clk(clk), .en(en), .a_i(trig_r[1]), .b_i(trig_r[1]), .p_o(hn2_raw)
  );
  gloh_mul #(.SHIFT(62)) u_mul_cr2 (
    .clk(clk), .en(en), .a_i(trig_r[2]), .b_i(trig_r[2]), .p_o(cr2_raw)
  );
  gloh_mul #(.SHIFT(62)) u_mul_crcg (
    .clk(clk), .en(en), .a_i(trig_r[2]), .b_i(trig_r[3]), .p_o(crcg)
  );

  assign hl2_c = gloh_pkg::clamp_unit(hl2_raw);

  gloh_mul #(.SHIFT(62)) u_mul_ax (
    .clk(clk), .en(en),
    .a_i(gloh_pkg::clamp_unit(cr2_raw)), .b_i(gloh_pkg::clamp_unit(hn2_raw)),
    .p_o(ax_raw)
  );
  gloh_mul #(.SHIFT(62)) u_mul_term (
    .clk(clk), .en(en), .a_i(crcg), .b_i(gloh_pkg::clamp_unit(hn2_raw)), .p_o(term)
  );

  gloh_dly #(.W(64), .N(3)) u_hl2_dly (
    .clk(clk), .en(en), .d_i(hl2_c), .q_o(hl2_d)
  );

  // Haversine a for the x, y and direct distances
  logic signed [63:0] a_r [0:2];
  logic signed [63:0] ad_sum;

  assign ad_sum = hl2_d + term;

  always_ff @(posedge clk) begin
    if (en) begin
      a_r[0] <= gloh_pkg::clamp_unit(ax_raw);
      a_r[1] <= hl2_d;
      a_r[2] <= (term > gloh_pkg::ONE_Q62 - hl2_d) ? gloh_pkg::ONE_Q62
                                                  : gloh_pkg::clamp_unit(ad_sum);
    end
  end

  // ---------------- arc length per distance ----------------
  logic signed [63:0] dist_w [0:2];

  for (genvar d = 0; d < 3; d++) begin : g_arc
    logic [63:0]        one_minus;
    logic [62:0]        ys, xs;
    logic signed [63:0] zang, zpos, cmm;

    assign one_minus = 64'(gloh_pkg::ONE_Q62 - a_r[d]);

    gloh_sqrt u_sqrt_a (
      .clk(clk), .en(en), .v_i(a_r[d][62:0]), .root_o(ys)
    );
    gloh_sqrt u_sqrt_b (
      .clk(clk), .en(en), .v_i(one_minus[62:0]), .root_o(xs)
    );

    gloh_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b1)) u_vec (
      .clk(clk), .en(en),
      .x_i({2'b00, xs[62:1]}), .y_i({2'b00, ys[62:1]}), .z_i(64'sd0),
      .x_o(), .y_o(), .z_o(zang)
    );

    // Drop negative angles, scale by the radius, round to millimeters
    assign zpos = (zang < 0) ? 64'sd0 : zang;

    gloh_mul #(.SHIFT(61)) u_mul_rad (
      .clk(clk), .en(en), .a_i(zpos), .b_i(gloh_pkg::RADIUS_CENTI_MM), .p_o(cmm)
    );
    gloh_mul #(.SHIFT(gloh_pkg::RECIP_SHIFT)) u_mul_div (
      .clk(clk), .en(en), .a_i(cmm + gloh_pkg::ROUND_HALF),
      .b_i(gloh_pkg::RECIP_100), .p_o(dist_w[d])
    );
  end

  // ---------------- result register ----------------
  logic signed [35:0] x_r, y_r;
  logic [34:0]        dist_r;
  logic               reached_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x_r       <= (sgn_d[0] ^ facing_r) ? -dist_w[0][35:0] : dist_w[0][35:0];
      y_r       <= (sgn_d[1] ^ facing_r) ? -dist_w[1][35:0] : dist_w[1][35:0];
      dist_r    <= dist_w[2][34:0];
      reached_r <= dist_w[2] < $signed({44'd0, thr_r});
    end
  end

  assign out_ch.valid        = vld_r[LAT-1];
  assign out_ch.x_offset_mm  = x_r;
  assign out_ch.y_offset_mm  = y_r;
  assign out_ch.distance_mm  = dist_r;
  assign out_ch.goal_reached = reached_r;

endmodule
